FILE: hdl/itoa_pkg.sv
// Shared types, character codes and digit lookup for the integer to ASCII block.
// Used by itoa_divider and integer_to_ascii_digits; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

   // Field widths fixed by the interface
   localparam int RADIX_BITS = 5;
   localparam int DIGIT_BITS = 4;
   localparam int CHAR_BITS  = 7;

   // Number bases
   localparam logic [RADIX_BITS-1:0] DEC_BASE  = 5'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = 5'd16;

   // Conversion modes
   localparam logic MODE_SIGNED_DEC = 1'b0;
   localparam logic MODE_UNSIGNED   = 1'b1;

   // ASCII codes
   localparam logic [CHAR_BITS-1:0] CH_ZERO  = 7'h30;
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 7'h2D;
   localparam logic [CHAR_BITS-1:0] CH_QUEST = 7'h3F;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 7'h41;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DIV  = 5'b00010,
      S_READ = 5'b00100,
      S_WAIT = 5'b01000,
      S_SHOW = 5'b10000
   } state_type;

   // Map a digit value 0..15 onto '0'-'9', 'A'-'F'
   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] ch;
      if (d < 4'd10) begin
         ch = CH_ZERO + {3'b000, d};
      end else begin
         ch = CH_UPPER_A + {3'b000, d - 4'd10};
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/itoa_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, small divisor.
// Depends on itoa_pkg for the divisor and remainder widths.
`timescale 1ns / 1ps
`default_nettype none

module itoa_divider #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [VALUE_BITS-1:0]              dividend,
   input  wire logic [itoa_pkg::RADIX_BITS-1:0]    divisor,
   output logic                                    done,
   output logic [VALUE_BITS-1:0]                   quotient,
   output logic [itoa_pkg::DIGIT_BITS-1:0]         remainder
);

   localparam int SW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [SW-1:0]                       cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0]               quo_ff, quo_in;
   logic [itoa_pkg::DIGIT_BITS-1:0]     rem_ff, rem_in;
   logic [itoa_pkg::RADIX_BITS-1:0]     div_ff, div_in;
   logic [itoa_pkg::RADIX_BITS-1:0]     trial;
   logic [itoa_pkg::RADIX_BITS-1:0]     trial_sub;
   logic                                qbit;

   // Shift in the next dividend bit and try the subtract
   always_comb begin
      trial     = {rem_ff, quo_ff[VALUE_BITS-1]};
      qbit      = (trial >= div_ff);
      trial_sub = qbit ? (trial - div_ff) : trial;
   end

   // Load on start, then step once per cycle until all bits are done
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (busy_ff) begin
         quo_in = {quo_ff[VALUE_BITS-2:0], qbit};
         rem_in = trial_sub[itoa_pkg::DIGIT_BITS-1:0];
         cnt_in = cnt_ff - SW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = SW'(VALUE_BITS - 1);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   // Remainder always ends below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ({1'b0, rem_ff} < div_ff))
      else $error("divider remainder not below divisor");

   // Completion frees the unit
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider busy while reporting done");

   // A start on an idle unit begins a division
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("divider did not start");

endmodule

`default_nettype wire

FILE: hdl/integer_to_ascii_digits.sv
// Top level of the integer to ASCII digit stream: sequencer, digit stack, output register.
// Depends on itoa_pkg and itoa_divider.
`timescale 1ns / 1ps
`default_nettype none

// Converts one VALUE_BITS-wide integer per transfer into ASCII characters, most
// significant first, one character per rsp transfer with rsp_last on the final one.
// Mode 0 shows the value as signed decimal with a leading '-'; mode 1 shows it
// unsigned in base 2..16 with digits 0-9, A-F; a bad base gives one '?' with
// rsp_bad_radix set. A single bit-serial divider produces the digits one at a time,
// least significant first, onto a digit stack that is read back in reverse; each
// character is held while rsp_stall is high. req_stall stays high from the accepted
// transfer until the last character is taken.
module integer_to_ascii_digits #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_mode,
   input  wire logic [VALUE_BITS-1:0]               req_value,
   input  wire logic [itoa_pkg::RADIX_BITS-1:0]     req_radix,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [itoa_pkg::CHAR_BITS-1:0]           rsp_char_out,
   output logic                                     rsp_last,
   output logic                                     rsp_bad_radix
);

   localparam int AW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int CW = $clog2(VALUE_BITS + 1);

   itoa_pkg::state_type                  state_ff, state_in;
   logic [CW-1:0]                        cnt_ff, cnt_in;
   logic                                 neg_ff, neg_in;
   logic [itoa_pkg::RADIX_BITS-1:0]      base_ff, base_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [itoa_pkg::CHAR_BITS-1:0]       rsp_char_ff, rsp_char_in;
   logic                                 rsp_last_ff, rsp_last_in;
   logic                                 rsp_bad_ff, rsp_bad_in;

   logic [itoa_pkg::DIGIT_BITS-1:0]      mem [VALUE_BITS];
   logic [itoa_pkg::DIGIT_BITS-1:0]      rd_data_ff;
   logic [CW-1:0]                        cnt_m1;
   logic                                 wr_en;

   logic                                 req_xfer;
   logic                                 rsp_xfer;
   logic                                 in_neg;
   logic                                 in_bad;
   logic [VALUE_BITS-1:0]                in_mag;
   logic [itoa_pkg::RADIX_BITS-1:0]      in_base;

   logic                                 div_start;
   logic [VALUE_BITS-1:0]                div_dividend;
   logic [itoa_pkg::RADIX_BITS-1:0]      div_divisor;
   logic                                 div_done;
   logic [VALUE_BITS-1:0]                div_quo;
   logic [itoa_pkg::DIGIT_BITS-1:0]      div_rem;

   assign req_stall = (state_ff != itoa_pkg::S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign cnt_m1    = cnt_ff - CW'(1);

   // Decode the incoming item: sign, magnitude and base
   always_comb begin
      in_neg  = (req_mode == itoa_pkg::MODE_SIGNED_DEC) && req_value[VALUE_BITS-1];
      in_mag  = in_neg ? (~req_value + VALUE_BITS'(1)) : req_value;
      in_base = (req_mode == itoa_pkg::MODE_SIGNED_DEC) ? itoa_pkg::DEC_BASE : req_radix;
      in_bad  = (req_mode == itoa_pkg::MODE_UNSIGNED) &&
                ((req_radix < itoa_pkg::RADIX_MIN) || (req_radix > itoa_pkg::RADIX_MAX));
   end

   // Start the divider on a new item, restart it while the quotient is nonzero
   assign div_start    = (req_xfer && !in_bad) ||
                         ((state_ff == itoa_pkg::S_DIV) && div_done && (div_quo != '0));
   assign div_dividend = (state_ff == itoa_pkg::S_IDLE) ? in_mag : div_quo;
   assign wr_en        = (state_ff == itoa_pkg::S_DIV) && div_done;

   // Take the base from the new item, then keep the held base for every restart
   assign div_divisor  = (state_ff == itoa_pkg::S_IDLE) ? in_base : base_ff;

   itoa_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Digit stack: push remainders, read back in reverse order
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[AW-1:0]] <= div_rem;
      end
      rd_data_ff <= mem[cnt_m1[AW-1:0]];
   end

   // Sequencer: divide, then unload the stack one character at a time
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      case (state_ff)
         itoa_pkg::S_IDLE: begin
            if (req_xfer) begin
               cnt_in  = '0;
               neg_in  = in_neg;
               base_in = in_base;
               if (in_bad) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = itoa_pkg::CH_QUEST;
                  rsp_last_in  = 1'b1;
                  rsp_bad_in   = 1'b1;
                  state_in     = itoa_pkg::S_SHOW;
               end else begin
                  state_in = itoa_pkg::S_DIV;
               end
            end
         end
         itoa_pkg::S_DIV: begin
            if (div_done) begin
               cnt_in = cnt_ff + CW'(1);
               if (div_quo == '0) begin
                  if (neg_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_char_in  = itoa_pkg::CH_MINUS;
                     rsp_last_in  = 1'b0;
                     rsp_bad_in   = 1'b0;
                     state_in     = itoa_pkg::S_SHOW;
                  end else begin
                     state_in = itoa_pkg::S_READ;
                  end
               end
            end
         end
         itoa_pkg::S_READ: begin
            cnt_in   = cnt_m1;
            state_in = itoa_pkg::S_WAIT;
         end
         itoa_pkg::S_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = itoa_pkg::digit_char(rd_data_ff);
            rsp_last_in  = (cnt_ff == '0);
            rsp_bad_in   = 1'b0;
            state_in     = itoa_pkg::S_SHOW;
         end
         itoa_pkg::S_SHOW: begin
            if (rsp_xfer) begin
               rsp_valid_in = 1'b0;
               state_in     = rsp_last_ff ? itoa_pkg::S_IDLE : itoa_pkg::S_READ;
            end
         end
         default: begin
            state_in     = itoa_pkg::S_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itoa_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      base_ff     <= base_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_out  = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_bad_radix = rsp_bad_ff;

   // A result is offered only from the show state
   a_valid_show: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == itoa_pkg::S_SHOW))
      else $error("result offered outside show state");

   // The error result is a lone final '?'
   a_bad_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_last_ff && (rsp_char_ff == itoa_pkg::CH_QUEST)))
      else $error("malformed bad radix result");

   // Divider completions arrive only while dividing
   a_done_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == itoa_pkg::S_DIV))
      else $error("divider done outside divide state");

   // Finishing the last character returns to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_last_ff) |=> (state_ff == itoa_pkg::S_IDLE))
      else $error("sequencer did not return to idle");

endmodule

`default_nettype wire

FILE: bench/digit_stream_checker.sv
// Checker for the integer to ASCII digit stream: watches both channels, spells each number
// it sees accepted, and compares every character transfer against that spelling.
// Depends on itoa_pkg for the character codes, bases and modes.
`timescale 1ns / 1ps

module digit_stream_checker #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_stall,
   input  wire logic                              req_mode,
   input  wire logic [VALUE_BITS-1:0]             req_value,
   input  wire logic [itoa_pkg::RADIX_BITS-1:0]   req_radix,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire logic [itoa_pkg::CHAR_BITS-1:0]    rsp_char_out,
   input  wire logic                              rsp_last,
   input  wire logic                              rsp_bad_radix,
   output int unsigned                            fail_count,
   output int unsigned                            chars_waiting,
   output int unsigned                            numbers_taken,
   output int unsigned                            chars_taken,
   output int unsigned                            bad_bases
);

   typedef struct packed {
      logic [itoa_pkg::CHAR_BITS-1:0] glyph;
      logic                           last;
      logic                           bad;
   } char_entry_type;

   // Digit set, '0' in the top byte
   localparam logic [127:0] GLYPHS = "0123456789ABCDEF";
   localparam int unsigned REPORT_CAP = 40;

   char_entry_type spelled_chars[$];
   int unsigned    fails = 0;
   int unsigned    numbers = 0;
   int unsigned    chars = 0;
   int unsigned    errors = 0;

   // Print one line per mismatch (up to a cap) and count every one
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (fails < REPORT_CAP) begin
         $display("%0t: character %0d: %s: got 'h%0h, expected 'h%0h",
                  $realtime, chars, what, got, want);
      end
      fails++;
   endtask

   // Append the characters that one number turns into
   function automatic void spell_number(input logic m, input logic [VALUE_BITS-1:0] v,
                                        input logic [itoa_pkg::RADIX_BITS-1:0] r);
      logic [VALUE_BITS-1:0]          mag;
      logic [VALUE_BITS-1:0]          base;
      logic [3:0]                     digit;
      logic                           negative;
      logic [itoa_pkg::CHAR_BITS-1:0] digits[$];
      char_entry_type                 e;
      negative = 1'b0;
      mag      = v;
      if (m == itoa_pkg::MODE_SIGNED_DEC) begin
         base = VALUE_BITS'(itoa_pkg::DEC_BASE);
         if (v[VALUE_BITS-1]) begin
            negative = 1'b1;
            // wraps to the right unsigned magnitude for the most negative value
            mag = -v;
         end
      end else if (r < itoa_pkg::RADIX_MIN || r > itoa_pkg::RADIX_MAX) begin
         e = '{glyph: itoa_pkg::CH_QUEST, last: 1'b1, bad: 1'b1};
         spelled_chars.push_back(e);
         errors++;
         return;
      end else begin
         base = VALUE_BITS'(r);
      end
      // Peel digits least significant first; zero still yields one digit
      do begin
         digit = 4'(mag % base);
         digits.push_front(GLYPHS[(15 - int'(digit)) * 8 +: itoa_pkg::CHAR_BITS]);
         mag = mag / base;
      end while (mag != 0);
      if (negative) begin
         e = '{glyph: itoa_pkg::CH_MINUS, last: 1'b0, bad: 1'b0};
         spelled_chars.push_back(e);
      end
      foreach (digits[i]) begin
         e = '{glyph: digits[i], last: (i == digits.size() - 1), bad: 1'b0};
         spelled_chars.push_back(e);
      end
   endfunction

   always @(posedge clock) begin : watch
      char_entry_type want;
      if (!reset) begin
         // Check the character transfer against the oldest spelled character
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (spelled_chars.size() == 0) begin
               report_mismatch("unexpected character", 32'(rsp_char_out), 0);
            end else begin
               want = spelled_chars.pop_front();
               if (rsp_char_out !== want.glyph)
                  report_mismatch("char_out", 32'(rsp_char_out), 32'(want.glyph));
               if (rsp_last !== want.last)
                  report_mismatch("last", 32'(rsp_last), 32'(want.last));
               if (rsp_bad_radix !== want.bad)
                  report_mismatch("bad_radix", 32'(rsp_bad_radix), 32'(want.bad));
            end
            chars++;
         end
         // Spell each number transfer
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            spell_number(req_mode, req_value, req_radix);
            numbers++;
         end
      end
      fail_count    <= fails;
      chars_waiting <= spelled_chars.size();
      numbers_taken <= numbers;
      chars_taken   <= chars;
      bad_bases     <= errors;
   end

endmodule

FILE: bench/tb_top.sv
// Top of the integer to ASCII digit stream bench: clock, reset, number and character
// traffic, and the verdict. Depends on itoa_pkg, integer_to_ascii_digits and digit_stream_checker.
`timescale 1ns / 1ps

module tb_top;

   localparam int          VALUE_BITS   = 32;
   localparam int unsigned RANDOM_ITEMS = 150;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned HOLD_AT      = 3000;
   localparam int unsigned HOLD_CYCLES  = 600;
   localparam int unsigned TAIL_CYCLES  = 64;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic                             req_mode = itoa_pkg::MODE_SIGNED_DEC;
   logic [VALUE_BITS-1:0]            req_value = '0;
   logic [itoa_pkg::RADIX_BITS-1:0]  req_radix = itoa_pkg::DEC_BASE;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [itoa_pkg::CHAR_BITS-1:0]   rsp_char_out;
   logic                             rsp_last;
   logic                             rsp_bad_radix;

   int unsigned fail_count;
   int unsigned chars_waiting;
   int unsigned numbers_taken;
   int unsigned chars_taken;
   int unsigned bad_bases;
   int unsigned cycle_count = 0;

   integer_to_ascii_digits #(.VALUE_BITS(VALUE_BITS)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .req_radix     (req_radix),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_out  (rsp_char_out),
      .rsp_last      (rsp_last),
      .rsp_bad_radix (rsp_bad_radix)
   );

   digit_stream_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .req_radix     (req_radix),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_out  (rsp_char_out),
      .rsp_last      (rsp_last),
      .rsp_bad_radix (rsp_bad_radix),
      .fail_count    (fail_count),
      .chars_waiting (chars_waiting),
      .numbers_taken (numbers_taken),
      .chars_taken   (chars_taken),
      .bad_bases     (bad_bases)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Count cycles and abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d characters still expected",
               cycle_count, chars_waiting);
      $display("TB_ERROR");
      $finish;
   end

   // Offer one number and hold it until the transfer happens
   task automatic offer_number(input logic m, input logic [VALUE_BITS-1:0] v,
                               input logic [itoa_pkg::RADIX_BITS-1:0] r);
      req_valid <= 1'b1;
      req_mode  <= m;
      req_value <= v;
      req_radix <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // Draw a value: full random, small, powers of two, edges, small negatives, shifted
   function automatic logic [VALUE_BITS-1:0] pick_value();
      logic [VALUE_BITS-1:0] v;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: v = $urandom_range(0, 20);
         2: v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
         3: begin
            case ($urandom_range(0, 3))
               0: v = 32'h0000_0000;
               1: v = 32'hFFFF_FFFF;
               2: v = 32'h8000_0000;
               default: v = 32'h7FFF_FFFF;
            endcase
         end
         4: v = -$urandom_range(1, 1000);
         default: v = $urandom >> $urandom_range(0, 31);
      endcase
      return v;
   endfunction

   // Receiver: stall in phases of varying density, with one long hold-off
   initial begin
      int unsigned stall_pct;
      int unsigned phase_left;
      int unsigned run_cycles;
      stall_pct  = 0;
      phase_left = 0;
      run_cycles = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         run_cycles++;
         if (run_cycles == HOLD_AT) begin
            // hold off while the sender keeps offering, so the block backs up
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (phase_left == 0) begin
            phase_left = $urandom_range(40, 200);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 20;
               2: stall_pct = 50;
               default: stall_pct = 90;
            endcase
         end
         phase_left--;
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Sender: directed numbers, then random bursts, then drain and verdict
   initial begin
      int unsigned                     burst_left;
      int unsigned                     gap;
      int unsigned                     draw;
      logic                            m;
      logic [itoa_pkg::RADIX_BITS-1:0] r;
      burst_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Signed decimal: zero, unit values, extremes, digit boundaries; radix ignored
      offer_number(itoa_pkg::MODE_SIGNED_DEC, 32'd0, 5'd0);
      offer_number(itoa_pkg::MODE_SIGNED_DEC, 32'd1, 5'd31);
      offer_number(itoa_pkg::MODE_SIGNED_DEC, 32'hFFFF_FFFF, 5'd2);
      offer_number(itoa_pkg::MODE_SIGNED_DEC, 32'h7FFF_FFFF, itoa_pkg::DEC_BASE);
      offer_number(itoa_pkg::MODE_SIGNED_DEC, 32'h8000_0000, 5'd16);
      offer_number(itoa_pkg::MODE_SIGNED_DEC, 32'd9, 5'd17);
      offer_number(itoa_pkg::MODE_SIGNED_DEC, 32'd10, 5'd1);
      offer_number(itoa_pkg::MODE_SIGNED_DEC, -32'sd10, 5'd10);
      offer_number(itoa_pkg::MODE_SIGNED_DEC, 32'd123456789, 5'd21);
      // Unsigned in a base: widest binary, hex letters, odd bases, zero
      offer_number(itoa_pkg::MODE_UNSIGNED, 32'hFFFF_FFFF, 5'd2);
      offer_number(itoa_pkg::MODE_UNSIGNED, 32'hFFFF_FFFF, 5'd16);
      offer_number(itoa_pkg::MODE_UNSIGNED, 32'hDEAD_BEEF, 5'd16);
      offer_number(itoa_pkg::MODE_UNSIGNED, 32'hABCD_EF01, 5'd16);
      offer_number(itoa_pkg::MODE_UNSIGNED, 32'h8000_0000, 5'd10);
      offer_number(itoa_pkg::MODE_UNSIGNED, 32'd1000, 5'd3);
      offer_number(itoa_pkg::MODE_UNSIGNED, 32'd0, 5'd7);
      offer_number(itoa_pkg::MODE_UNSIGNED, 32'd0, 5'd2);
      offer_number(itoa_pkg::MODE_UNSIGNED, 32'h1234_5678, 5'd15);
      // Bad bases on both sides of the valid range
      offer_number(itoa_pkg::MODE_UNSIGNED, 32'd55, 5'd0);
      offer_number(itoa_pkg::MODE_UNSIGNED, 32'hFFFF_FFFF, 5'd1);
      offer_number(itoa_pkg::MODE_UNSIGNED, 32'd0, 5'd17);
      offer_number(itoa_pkg::MODE_UNSIGNED, 32'h8000_0000, 5'd31);

      // Random numbers in bursts separated by random gaps
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 20);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         draw = $urandom_range(0, 1);
         m = draw[0];
         if ($urandom_range(0, 99) < 85) begin
            draw = $urandom_range(itoa_pkg::RADIX_MIN, itoa_pkg::RADIX_MAX);
         end else begin
            draw = $urandom_range(0, 31);
         end
         r = draw[itoa_pkg::RADIX_BITS-1:0];
         offer_number(m, pick_value(), r);
      end
      req_valid <= 1'b0;

      // Drain, then give stray characters time to show up
      @(posedge clock);
      while (chars_waiting != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Converted %0d numbers into %0d characters, %0d of them bad-base errors,",
               numbers_taken, chars_taken, bad_bases);
      $display("over %0d cycles with bursty input and a long receiver hold-off.", cycle_count);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
